// ----- hdl/ctms_pkg.sv -----
package ctms_pkg;

  localparam int SAMPLES_PER_CHANNEL = 10;
  localparam int CHANNELS = 3;
  localparam int BUF_DEPTH = CHANNELS * SAMPLES_PER_CHANNEL;
  localparam int ADDR_W = $clog2(BUF_DEPTH);

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W = 2;
  localparam int LEVEL_W = 9;

  localparam int CNT_W = $clog2(SAMPLES_PER_CHANNEL);
  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_CHANNEL);
  localparam int TRIM_COUNT = SAMPLES_PER_CHANNEL - 2;

  // Full-scale code is 2^SAMPLE_W - 1; the scaler relies on that.
  localparam int FULL_SCALE_CODE = 4095;
  localparam int FULL_SCALE_CENTIVOLTS = 330;
  localparam int SCALE_W = $clog2(FULL_SCALE_CENTIVOLTS + 1);
  localparam int PROD_W = SAMPLE_W + SCALE_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DRAIN,
    BK_TRIM,
    BK_SCALE,
    BK_DONE
  } back_state_e;

endpackage

// ----- hdl/ctms_ram.sv -----
module ctms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ctms_front.sv -----
module ctms_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [ctms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [ctms_pkg::CHAN_W-1:0]   channel_i,
  output logic                          req_valid_o,
  output ctms_pkg::req_t                req_o,
  input  logic                          req_ready_i
);
  import ctms_pkg::*;

  req_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              accept;
  logic              keep;
  logic              push;
  logic              pop;
  req_t              new_req;

  // Queries of a channel that does not exist are dropped here.
  assign in_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign accept = in_valid_i && in_ready_o;
  assign keep = (command_i == CMD_STORE) || (channel_i < CHANNELS);
  assign push = accept && keep;
  assign pop = req_valid_o && req_ready_i;

  always_comb begin
    new_req.cmd = cmd_e'(command_i);
    new_req.sample = sample_i;
    new_req.channel = channel_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_req;
    end
  end

  assign req_valid_o = (count_q != '0);
  assign req_o = slot_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond its depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count did not follow a push");

endmodule

// ----- hdl/ctms_back.sv -----
module ctms_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  ctms_pkg::req_t               req_i,
  output logic                         req_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ctms_pkg::LEVEL_W-1:0] level_o
);
  import ctms_pkg::*;

  back_state_e          state_q, state_d;
  logic [ADDR_W-1:0]    slot_q;
  logic [BUF_DEPTH-1:0] filled_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [CNT_W-1:0]     issue_cnt_q;
  logic                 rd_pend_q;
  logic                 rd_hit_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SAMPLE_W-1:0]  lo_q, hi_q;
  logic [SAMPLE_W-1:0]  avg_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_valid_q;
  logic [LEVEL_W-1:0]   level_q;

  logic                 req_pop;
  logic                 mem_we;
  logic                 mem_re;
  logic                 last_issue;
  logic                 out_load;
  logic [SAMPLE_W-1:0]  rd_data;
  logic [SAMPLE_W-1:0]  rd_value;
  logic [SUM_W-1:0]     trimmed;
  logic [LEVEL_W-1:0]   quot_base;
  logic [SAMPLE_W:0]    quot_rem;
  logic [LEVEL_W-1:0]   level_d;

  ctms_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(slot_q),
    .wdata_i(req_i.sample),
    .re_i   (mem_re),
    .raddr_i(addr_q),
    .rdata_o(rd_data)
  );

  // Control outputs, decoded from the state and the handshake inputs.
  always_comb begin
    req_pop = (state_q == BK_IDLE) && req_valid_i;
    mem_we = req_pop && (req_i.cmd == CMD_STORE);
    mem_re = (state_q == BK_READ);
    last_issue = mem_re && (issue_cnt_q == CNT_W'(SAMPLES_PER_CHANNEL - 1));
    out_load = (state_q == BK_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (req_valid_i && (req_i.cmd == CMD_QUERY)) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        if (last_issue) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: state_d = BK_TRIM;
      BK_TRIM:  state_d = BK_SCALE;
      BK_SCALE: state_d = BK_DONE;
      BK_DONE: begin
        if (out_load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // A slot that was never written reads as zero.
  assign rd_value = rd_hit_q ? rd_data : '0;
  assign trimmed = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);

  // Division by 4095 = 2^12 - 1: x = q*4096 + r12 = q*4095 + (q + r12).
  // The remainder estimate stays below twice the divisor, so a single
  // correction step completes the quotient.
  assign quot_base = prod_q[PROD_W-1:SAMPLE_W];
  assign quot_rem = {1'b0, prod_q[SAMPLE_W-1:0]} + (SAMPLE_W + 1)'(quot_base);
  assign level_d = (quot_rem >= (SAMPLE_W + 1)'(FULL_SCALE_CODE)) ?
                   quot_base + 1'b1 : quot_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      slot_q <= '0;
      filled_q <= '0;
      rd_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_pend_q <= mem_re;
      if (mem_we) begin
        filled_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == ADDR_W'(BUF_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop && (req_i.cmd == CMD_QUERY)) begin
      addr_q <= ADDR_W'(req_i.channel);
      issue_cnt_q <= '0;
      sum_q <= '0;
      lo_q <= '1;
      hi_q <= '0;
    end
    if (mem_re) begin
      rd_hit_q <= filled_q[addr_q];
      addr_q <= ADDR_W'(addr_q + ADDR_W'(CHANNELS));
      issue_cnt_q <= issue_cnt_q + 1'b1;
    end
    if (rd_pend_q) begin
      sum_q <= sum_q + SUM_W'(rd_value);
      if (rd_value < lo_q) begin
        lo_q <= rd_value;
      end
      if (rd_value > hi_q) begin
        hi_q <= rd_value;
      end
    end
    if (state_q == BK_TRIM) begin
      avg_q <= SAMPLE_W'(trimmed / TRIM_COUNT);
    end
    if (state_q == BK_SCALE) begin
      prod_q <= PROD_W'(avg_q) * PROD_W'(FULL_SCALE_CENTIVOLTS);
    end
    if (out_load) begin
      level_q <= level_d;
    end
  end

  assign req_ready_o = (state_q == BK_IDLE);
  assign out_valid_o = out_valid_q;
  assign level_o = level_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (level_q <= LEVEL_W'(FULL_SCALE_CENTIVOLTS)))
    else $error("level above full scale");

  a_read_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == BK_READ))
    else $error("read data pending without a read issued");

  a_trim_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_TRIM) |-> !rd_pend_q)
    else $error("trim started before the last sample was accumulated");

endmodule

// ----- hdl/channel_trimmed_mean_scaler.sv -----
// Trimmed-mean level monitor for a three-channel converter scan.
//
// Input channel (in_valid_i / in_ready_o): each request is either a store
// (command_i low), which writes sample_i into the next slot of a 30-entry
// circular buffer, or a query (command_i high), which names the scan
// position channel_i. Slot k belongs to channel k mod 3. A query of a
// channel position that does not exist is accepted and dropped.
// Output channel (out_valid_o / out_ready_i): one level_o per valid query,
// the mean of the channel's ten samples without one smallest and one
// largest, scaled to hundredths of a volt (0 to 330).
//
// Timing: a store executes in the idle state; the execution side can take
// the next request right after it. A query reads its ten samples one per
// cycle from the buffer RAM, then trims, scales and divides; it holds the
// execution side until its level is loaded, so no new query starts before
// the last is through. A two-entry request queue in front keeps taking
// requests meanwhile. When the receiver stalls, the level is held and stores
// keep executing; the next finished level waits in DONE until the held one is taken.
// Reset clears the buffer's valid flags (empty slots read as zero), the
// write slot, the queue and the output valid flag.
module channel_trimmed_mean_scaler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [ctms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [ctms_pkg::CHAN_W-1:0]   channel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ctms_pkg::LEVEL_W-1:0] level_o
);
  import ctms_pkg::*;

  // Request handoff between the accepting front and the executing back.
  logic req_valid;
  logic req_ready;
  req_t req;

  ctms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sample_i   (sample_i),
    .channel_i  (channel_i),
    .req_valid_o(req_valid),
    .req_o      (req),
    .req_ready_i(req_ready)
  );

  // The back owns the sample buffer, the write slot and the output register.
  ctms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_i      (req),
    .req_ready_o(req_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .level_o    (level_o)
  );

endmodule
